/* rtl/e2n_pkg.sv */
// shared types and constants for the enu to ned odometry converter
package e2n_pkg;

    // operation codes of the shared iterative unit
    localparam logic IU_OP_DIV  = 1'b0;
    localparam logic IU_OP_SQRT = 1'b1;

    // quotient bits produced per division, steps per square root
    localparam int DIV_QBITS   = 34;
    localparam int SQRT_STEPS  = 32;
    localparam int IU_CNT_W    = $clog2(DIV_QBITS + 1);

    typedef struct packed {
        logic start;
        logic op;
    } iu_req_t;

    // negate one q7.8 lane, saturating the most negative value
    function automatic logic [15:0] neg_sat16(input logic [15:0] v);
        logic [15:0] r;
        r = (v == 16'h8000) ? 16'h7fff : 16'(-v);
        return r;
    endfunction

    // keep x, negate y and z of a packed velocity triple
    function automatic logic [47:0] flip_vel(input logic [47:0] p);
        logic [47:0] r;
        r = {neg_sat16(p[47:32]), neg_sat16(p[31:16]), p[15:0]};
        return r;
    endfunction

endpackage

/* rtl/e2n_iter_unit.sv */
// shared iterative divider and square root unit, one bit per cycle
module e2n_iter_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  e2n_pkg::iu_req_t req,
    input  logic [63:0]      num,
    input  logic [63:0]      den,
    output logic             done,
    output logic [63:0]      res
);

    logic                          busy_reg, busy_next;
    logic                          op_reg, op_next;
    logic [e2n_pkg::IU_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                          done_reg, done_next;
    logic [63:0]                   x_reg, x_next;   // dividend bits / radicand
    logic [63:0]                   y_reg, y_next;   // remainder / root
    logic [63:0]                   z_reg, z_next;   // divisor / trial bit
    logic [e2n_pkg::DIV_QBITS-1:0] q_reg, q_next;
    logic [63:0]                   res_reg, res_next;

    logic [64:0] rem_sh;
    logic        rem_ge;
    logic [63:0] sq_sum;
    logic        sq_ge;
    logic        ovf;

    always_comb
    begin
        rem_sh = {y_reg, x_reg[63]};
        rem_ge = rem_sh >= {1'b0, z_reg};
        sq_sum = y_reg + z_reg;
        sq_ge  = x_reg >= sq_sum;
        ovf    = (num >> e2n_pkg::DIV_QBITS) >= den;

        busy_next = busy_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        q_next    = q_reg;
        res_next  = res_reg;

        if (!busy_reg && req.start)
        begin
            op_next = req.op;
            if (req.op == e2n_pkg::IU_OP_SQRT)
            begin
                busy_next = 1'b1;
                cnt_next  = e2n_pkg::IU_CNT_W'(e2n_pkg::SQRT_STEPS);
                x_next    = num;
                y_next    = '0;
                z_next    = 64'd1 << 62;
            end
            else if (ovf)
            begin
                // quotient does not fit, report all ones
                done_next = 1'b1;
                res_next  = '1;
            end
            else
            begin
                busy_next = 1'b1;
                cnt_next  = e2n_pkg::IU_CNT_W'(e2n_pkg::DIV_QBITS);
                x_next    = num << (64 - e2n_pkg::DIV_QBITS);
                y_next    = num >> e2n_pkg::DIV_QBITS;
                z_next    = den;
                q_next    = '0;
            end
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (op_reg == e2n_pkg::IU_OP_SQRT)
            begin
                if (sq_ge)
                begin
                    x_next = x_reg - sq_sum;
                    y_next = (y_reg >> 1) + z_reg;
                end
                else
                begin
                    y_next = y_reg >> 1;
                end
                z_next = z_reg >> 2;
                if (cnt_reg == 1)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                    res_next  = sq_ge ? (y_reg >> 1) + z_reg : y_reg >> 1;
                end
            end
            else
            begin
                x_next = x_reg << 1;
                y_next = rem_ge ? 64'(rem_sh - {1'b0, z_reg}) : rem_sh[63:0];
                q_next = {q_reg[e2n_pkg::DIV_QBITS-2:0], rem_ge};
                if (cnt_reg == 1)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                    res_next  = 64'({q_reg[e2n_pkg::DIV_QBITS-2:0], rem_ge});
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= e2n_pkg::IU_OP_DIV;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        q_reg   <= q_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

/* rtl/enu_to_ned_odometry_converter.sv */
// top level of the enu/flu to ned/frd odometry converter
//
// takes one odometry request at a time and returns one result per request.
// position comes out as ned relative to an origin latched by the first valid
// sample (and again after any backwards step in time), velocities have y and
// z negated, and the orientation quaternion is rebuilt through its rotation
// matrix. a request with an all-zero quaternion returns a result with
// valid_res low and every other field zero, leaving the state alone. a
// converted request forms ten products on the one 16x16 multiplier, forms
// the matrix terms (ST_MAT) and selects among them (ST_BR), then runs seven
// divisions and one square root on the single shared bit-serial unit (34
// and 32 steps, each launched in ST_GO and taken in ST_WAIT), and loads
// the output registers; a zero root skips the remaining divisions and
// leaves the quaternion zero. an all-zero request skips the arithmetic and
// goes straight to ST_DONE. in_ready is high only while no request is being
// worked on; a finished result sits in the output registers until taken,
// and the next request can be accepted meanwhile.
module enu_to_ned_odometry_converter #(
    parameter int POS_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [63:0]                 time_usec,
    input  logic signed [POS_WIDTH-1:0] pos_x,
    input  logic signed [POS_WIDTH-1:0] pos_y,
    input  logic signed [POS_WIDTH-1:0] pos_z,
    input  logic signed [15:0]          quat_w,
    input  logic signed [15:0]          quat_x,
    input  logic signed [15:0]          quat_y,
    input  logic signed [15:0]          quat_z,
    input  logic [47:0]                 lin_vel,
    input  logic [47:0]                 ang_vel,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        valid_res,
    output logic [63:0]                 out_time_usec,
    output logic signed [POS_WIDTH-1:0] north,
    output logic signed [POS_WIDTH-1:0] east,
    output logic signed [POS_WIDTH-1:0] down,
    output logic signed [15:0]          out_quat_w,
    output logic signed [15:0]          out_quat_x,
    output logic signed [15:0]          out_quat_y,
    output logic signed [15:0]          out_quat_z,
    output logic [47:0]                 out_lin_vel,
    output logic [47:0]                 out_ang_vel,
    output logic [7:0]                  reset_count
);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_MAT  = 3'd2;
    localparam logic [2:0] ST_BR   = 3'd3;
    localparam logic [2:0] ST_GO   = 3'd4;
    localparam logic [2:0] ST_WAIT = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    // what the shared unit is working on
    localparam logic [1:0] PH_R  = 2'd0;   // a * 2^28 / n2
    localparam logic [1:0] PH_SQ = 2'd1;   // sqrt(r * 2^30)
    localparam logic [1:0] PH_T  = 2'd2;   // |d| * 2^28 / n2, rounded
    localparam logic [1:0] PH_V  = 2'd3;   // t * 2^14 / cs, rounded

    localparam int NPROD = 10;

    // control state
    logic [2:0]  state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  mul_idx_reg, mul_idx_next;
    logic [1:0]  k_reg, k_next;
    logic        out_valid_reg, out_valid_next;
    logic        have_time_reg, have_time_next;
    logic        have_org_reg, have_org_next;
    logic [7:0]  rev_cnt_reg, rev_cnt_next;

    // history
    logic [63:0]                 last_time_reg;
    logic signed [POS_WIDTH-1:0] org_x_reg, org_y_reg, org_z_reg;

    // request held while it is converted
    logic signed [15:0]          qin_reg [0:3];
    logic                        vld_p_reg;
    logic [63:0]                 time_p_reg;
    logic signed [POS_WIDTH-1:0] north_p_reg, east_p_reg, down_p_reg;
    logic [47:0]                 lv_p_reg, av_p_reg;

    // quaternion working registers
    logic signed [31:0] prod_reg [0:NPROD-1];
    logic signed [35:0] m_reg [0:8];
    logic [32:0]        n2_reg;
    logic [34:0]        a_reg;
    logic signed [36:0] d_reg [0:2];
    logic [1:0]         main_reg;
    logic [32:0]        r_reg;
    logic [31:0]        cs_reg;
    logic [63:0]        t_reg;
    logic signed [15:0] qout_reg [0:3];

    // output registers
    logic                        valid_res_reg;
    logic [63:0]                 time_o_reg;
    logic signed [POS_WIDTH-1:0] north_reg, east_reg, down_reg;
    logic signed [15:0]          qo_w_reg, qo_x_reg, qo_y_reg, qo_z_reg;
    logic [47:0]                 lv_o_reg, av_o_reg;
    logic [7:0]                  cnt_o_reg;

    // shared unit
    e2n_pkg::iu_req_t iu_req;
    logic [63:0]      iu_num, iu_den, iu_res;
    logic             iu_done;

    e2n_iter_unit u_iter (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (iu_req),
        .num  (iu_num),
        .den  (iu_den),
        .done (iu_done),
        .res  (iu_res)
    );

    // saturate a widened difference back to the position width
    function automatic logic [POS_WIDTH-1:0] sat_pos(input logic [POS_WIDTH:0] v);
        logic [POS_WIDTH-1:0] r;
        if (v[POS_WIDTH] != v[POS_WIDTH-1])
            r = v[POS_WIDTH] ? {1'b1, {(POS_WIDTH-1){1'b0}}} : {1'b0, {(POS_WIDTH-1){1'b1}}};
        else
            r = v[POS_WIDTH-1:0];
        return r;
    endfunction

    logic accept;
    logic quat_zero;
    logic reversal;
    logic org_keep;
    logic signed [POS_WIDTH-1:0] ox, oy, oz;
    logic [POS_WIDTH:0] dn, de, dd;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign quat_zero = (quat_w == 16'sd0) && (quat_x == 16'sd0) &&
                       (quat_y == 16'sd0) && (quat_z == 16'sd0);
    assign reversal  = have_time_reg && (time_usec < last_time_reg);
    // origin survives only if one exists and time did not step back
    assign org_keep  = have_org_reg && !reversal;
    assign ox = org_keep ? org_x_reg : pos_x;
    assign oy = org_keep ? org_y_reg : pos_y;
    assign oz = org_keep ? org_z_reg : pos_z;
    assign dn = {pos_y[POS_WIDTH-1], pos_y} - {oy[POS_WIDTH-1], oy};
    assign de = {pos_x[POS_WIDTH-1], pos_x} - {ox[POS_WIDTH-1], ox};
    assign dd = {oz[POS_WIDTH-1], oz} - {pos_z[POS_WIDTH-1], pos_z};

    // multiplier operand selection, one product per cycle
    logic signed [15:0] mul_a, mul_b;

    always_comb
    begin
        unique case (mul_idx_reg)
            4'd0:    begin mul_a = qin_reg[0]; mul_b = qin_reg[0]; end  // ww
            4'd1:    begin mul_a = qin_reg[1]; mul_b = qin_reg[1]; end  // xx
            4'd2:    begin mul_a = qin_reg[2]; mul_b = qin_reg[2]; end  // yy
            4'd3:    begin mul_a = qin_reg[3]; mul_b = qin_reg[3]; end  // zz
            4'd4:    begin mul_a = qin_reg[1]; mul_b = qin_reg[2]; end  // xy
            4'd5:    begin mul_a = qin_reg[3]; mul_b = qin_reg[0]; end  // zw
            4'd6:    begin mul_a = qin_reg[1]; mul_b = qin_reg[3]; end  // xz
            4'd7:    begin mul_a = qin_reg[2]; mul_b = qin_reg[0]; end  // yw
            4'd8:    begin mul_a = qin_reg[2]; mul_b = qin_reg[3]; end  // yz
            4'd9:    begin mul_a = qin_reg[1]; mul_b = qin_reg[0]; end  // xw
            default: begin mul_a = '0;         mul_b = '0;         end
        endcase
    end

    // rotation matrix, scaled by n2, with the ned/frd axis permutation folded in
    logic signed [35:0] pww, pxx, pyy, pzz, pxy, pzw, pxz, pyw, pyz, pxw, n2s;
    logic signed [35:0] m_new [0:8];

    always_comb
    begin
        pww = 36'(prod_reg[0]);
        pxx = 36'(prod_reg[1]);
        pyy = 36'(prod_reg[2]);
        pzz = 36'(prod_reg[3]);
        pxy = 36'(prod_reg[4]);
        pzw = 36'(prod_reg[5]);
        pxz = 36'(prod_reg[6]);
        pyw = 36'(prod_reg[7]);
        pyz = 36'(prod_reg[8]);
        pxw = 36'(prod_reg[9]);
        n2s = pww + pxx + pyy + pzz;
        m_new[0] = (pxy + pzw) <<< 1;
        m_new[1] = ((pxx + pzz) <<< 1) - n2s;
        m_new[2] = (pxw - pyz) <<< 1;
        m_new[3] = n2s - ((pyy + pzz) <<< 1);
        m_new[4] = (pzw - pxy) <<< 1;
        m_new[5] = -((pxz + pyw) <<< 1);
        m_new[6] = (pyw - pxz) <<< 1;
        m_new[7] = (pyz + pxw) <<< 1;
        m_new[8] = n2s - ((pxx + pyy) <<< 1);
    end

    // shepperd branch selection
    logic signed [38:0] tr, a_sel;
    logic signed [38:0] e00, e11, e22, n2e;
    logic signed [36:0] d_sel [0:2];
    logic [1:0]         main_sel;
    logic [34:0]        a_clamp;

    always_comb
    begin
        e00 = 39'(m_reg[0]);
        e11 = 39'(m_reg[4]);
        e22 = 39'(m_reg[8]);
        n2e = 39'({1'b0, n2_reg});
        tr  = e00 + e11 + e22;
        priority if (tr > 0)
        begin
            a_sel    = n2e + tr;
            main_sel = 2'd0;
            d_sel[0] = 37'(m_reg[7]) - 37'(m_reg[5]);
            d_sel[1] = 37'(m_reg[2]) - 37'(m_reg[6]);
            d_sel[2] = 37'(m_reg[3]) - 37'(m_reg[1]);
        end
        else if (e00 > e11 && e00 > e22)
        begin
            a_sel    = n2e + e00 - e11 - e22;
            main_sel = 2'd1;
            d_sel[0] = 37'(m_reg[7]) - 37'(m_reg[5]);
            d_sel[1] = 37'(m_reg[1]) + 37'(m_reg[3]);
            d_sel[2] = 37'(m_reg[2]) + 37'(m_reg[6]);
        end
        else if (e11 > e22)
        begin
            a_sel    = n2e + e11 - e00 - e22;
            main_sel = 2'd2;
            d_sel[0] = 37'(m_reg[2]) - 37'(m_reg[6]);
            d_sel[1] = 37'(m_reg[1]) + 37'(m_reg[3]);
            d_sel[2] = 37'(m_reg[5]) + 37'(m_reg[7]);
        end
        else
        begin
            a_sel    = n2e + e22 - e00 - e11;
            main_sel = 2'd3;
            d_sel[0] = 37'(m_reg[3]) - 37'(m_reg[1]);
            d_sel[1] = 37'(m_reg[2]) + 37'(m_reg[6]);
            d_sel[2] = 37'(m_reg[5]) + 37'(m_reg[7]);
        end
        if (a_sel <= 0)
            a_clamp = '0;
        else if (a_sel > 39'sd17179869184)
            a_clamp = 35'd17179869184;
        else
            a_clamp = a_sel[34:0];
    end

    // operands for the shared unit, and the side component finishing
    logic signed [36:0] d_cur;
    logic [36:0]        d_mag;
    logic [64:0]        d_sh;
    logic [1:0]         slot;
    logic [32:0]        cs_rnd;
    logic [15:0]        main_q;
    logic [15:0]        side_q;

    always_comb
    begin
        d_cur  = d_reg[k_reg];
        d_mag  = d_cur[36] ? 37'(-d_cur) : 37'(d_cur);
        d_sh   = 65'(d_mag) << 28;
        // side components fill the slots around the main one
        slot   = (k_reg >= main_reg) ? k_reg + 2'd1 : k_reg;
        cs_rnd = 33'(iu_res[31:0]) + 33'h8000;
        main_q = (cs_rnd[32:16] > 17'd32767) ? 16'h7fff : cs_rnd[31:16];
        if (d_cur[36])
            side_q = (iu_res > 64'd32768) ? 16'h8000 : 16'(-iu_res[15:0]);
        else
            side_q = (iu_res > 64'd32767) ? 16'h7fff : iu_res[15:0];

        iu_req.start = (state_reg == ST_GO);
        iu_req.op    = (phase_reg == PH_SQ) ? e2n_pkg::IU_OP_SQRT : e2n_pkg::IU_OP_DIV;
        unique case (phase_reg)
            PH_R:
            begin
                iu_num = 64'({a_reg, 28'd0});
                iu_den = 64'(n2_reg);
            end
            PH_SQ:
            begin
                iu_num = 64'({r_reg, 30'd0});
                iu_den = '0;
            end
            PH_T:
            begin
                iu_num = d_sh[63:0] + 64'(n2_reg >> 1);
                iu_den = 64'(n2_reg);
            end
            PH_V:
            begin
                iu_num = (t_reg << 14) + 64'(cs_reg >> 1);
                iu_den = 64'(cs_reg);
            end
            default:
            begin
                iu_num = '0;
                iu_den = '0;
            end
        endcase
    end

    // sequencer
    logic load_out;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        mul_idx_next   = mul_idx_reg;
        k_next         = k_reg;
        have_time_next = have_time_reg;
        have_org_next  = have_org_reg;
        rev_cnt_next   = rev_cnt_reg;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (quat_zero)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next     = ST_MUL;
                        mul_idx_next   = '0;
                        have_time_next = 1'b1;
                        have_org_next  = 1'b1;
                        if (reversal)
                            rev_cnt_next = rev_cnt_reg + 8'd1;
                    end
                end
            end
            ST_MUL:
            begin
                mul_idx_next = mul_idx_reg + 4'd1;
                if (mul_idx_reg == 4'(NPROD - 1))
                    state_next = ST_MAT;
            end
            ST_MAT:
            begin
                state_next = ST_BR;
            end
            ST_BR:
            begin
                state_next = ST_GO;
                phase_next = PH_R;
            end
            ST_GO:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (iu_done)
                begin
                    state_next = ST_GO;
                    unique case (phase_reg)
                        PH_R:  phase_next = PH_SQ;
                        PH_SQ:
                        begin
                            k_next = '0;
                            if (iu_res[31:0] == 32'd0)
                                state_next = ST_DONE;
                            else
                                phase_next = PH_T;
                        end
                        PH_T:  phase_next = PH_V;
                        PH_V:
                        begin
                            k_next     = k_reg + 2'd1;
                            phase_next = PH_T;
                            if (k_reg == 2'd2)
                                state_next = ST_DONE;
                        end
                        default: phase_next = PH_R;
                    endcase
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_R;
            mul_idx_reg   <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            have_time_reg <= 1'b0;
            have_org_reg  <= 1'b0;
            rev_cnt_reg   <= '0;
            last_time_reg <= '0;
            org_x_reg     <= '0;
            org_y_reg     <= '0;
            org_z_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            mul_idx_reg   <= mul_idx_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            have_time_reg <= have_time_next;
            have_org_reg  <= have_org_next;
            rev_cnt_reg   <= rev_cnt_next;
            if (accept && !quat_zero)
            begin
                last_time_reg <= time_usec;
                org_x_reg     <= ox;
                org_y_reg     <= oy;
                org_z_reg     <= oz;
            end
        end
    end

    // payload path
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qin_reg[0]  <= quat_w;
            qin_reg[1]  <= quat_x;
            qin_reg[2]  <= quat_y;
            qin_reg[3]  <= quat_z;
            vld_p_reg   <= !quat_zero;
            time_p_reg  <= time_usec;
            north_p_reg <= sat_pos(dn);
            east_p_reg  <= sat_pos(de);
            down_p_reg  <= sat_pos(dd);
            lv_p_reg    <= e2n_pkg::flip_vel(lin_vel);
            av_p_reg    <= e2n_pkg::flip_vel(ang_vel);
            for (int i = 0; i < 4; i++)
                qout_reg[i] <= '0;
        end
        if (state_reg == ST_MUL)
            prod_reg[mul_idx_reg] <= mul_a * mul_b;
        if (state_reg == ST_MAT)
        begin
            for (int i = 0; i < 9; i++)
                m_reg[i] <= m_new[i];
            n2_reg <= n2s[32:0];
        end
        if (state_reg == ST_BR)
        begin
            a_reg    <= a_clamp;
            main_reg <= main_sel;
            for (int i = 0; i < 3; i++)
                d_reg[i] <= d_sel[i];
        end
        if (state_reg == ST_WAIT && iu_done)
        begin
            unique case (phase_reg)
                PH_R:  r_reg <= (iu_res > 64'h1_0000_0000) ? 33'h1_0000_0000 : iu_res[32:0];
                PH_SQ:
                begin
                    cs_reg <= iu_res[31:0];
                    if (iu_res[31:0] != 32'd0)
                        qout_reg[main_reg] <= main_q;
                end
                PH_T:  t_reg <= iu_res;
                PH_V:  qout_reg[slot] <= side_q;
                default: t_reg <= t_reg;
            endcase
        end
        if (load_out)
        begin
            // an all-zero quaternion gives an all-zero result
            valid_res_reg <= vld_p_reg;
            time_o_reg    <= vld_p_reg ? time_p_reg : '0;
            north_reg     <= vld_p_reg ? north_p_reg : '0;
            east_reg      <= vld_p_reg ? east_p_reg : '0;
            down_reg      <= vld_p_reg ? down_p_reg : '0;
            qo_w_reg      <= qout_reg[0];
            qo_x_reg      <= qout_reg[1];
            qo_y_reg      <= qout_reg[2];
            qo_z_reg      <= qout_reg[3];
            lv_o_reg      <= vld_p_reg ? lv_p_reg : '0;
            av_o_reg      <= vld_p_reg ? av_p_reg : '0;
            cnt_o_reg     <= vld_p_reg ? rev_cnt_reg : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign valid_res     = valid_res_reg;
    assign out_time_usec = time_o_reg;
    assign north         = north_reg;
    assign east          = east_reg;
    assign down          = down_reg;
    assign out_quat_w    = qo_w_reg;
    assign out_quat_x    = qo_x_reg;
    assign out_quat_y    = qo_y_reg;
    assign out_quat_z    = qo_z_reg;
    assign out_lin_vel   = lv_o_reg;
    assign out_ang_vel   = av_o_reg;
    assign reset_count   = cnt_o_reg;

`ifndef SYNTHESIS
    // a zero quaternion skips the arithmetic entirely
    a_zero_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && quat_zero) |=> (state_reg == ST_DONE))
        else $error("zero quaternion request did not go straight to done");

    // the shared unit only answers while the sequencer waits for it
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        iu_done |-> (state_reg == ST_WAIT))
        else $error("iterative unit finished outside the wait state");

    // reversal counter moves only on an accepted request
    a_rev_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(rev_cnt_reg))
        else $error("reset counter changed without a request");
`endif

endmodule

/* bench/enu_to_ned_odometry_checker.sv */
// checker for the enu to ned odometry converter: predicts each result and compares it
module enu_to_ned_odometry_checker #(
    parameter int POS_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [63:0]                 time_usec,
    input  logic signed [POS_WIDTH-1:0] pos_x,
    input  logic signed [POS_WIDTH-1:0] pos_y,
    input  logic signed [POS_WIDTH-1:0] pos_z,
    input  logic signed [15:0]          quat_w,
    input  logic signed [15:0]          quat_x,
    input  logic signed [15:0]          quat_y,
    input  logic signed [15:0]          quat_z,
    input  logic [47:0]                 lin_vel,
    input  logic [47:0]                 ang_vel,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        valid_res,
    input  logic [63:0]                 out_time_usec,
    input  logic signed [POS_WIDTH-1:0] north,
    input  logic signed [POS_WIDTH-1:0] east,
    input  logic signed [POS_WIDTH-1:0] down,
    input  logic signed [15:0]          out_quat_w,
    input  logic signed [15:0]          out_quat_x,
    input  logic signed [15:0]          out_quat_y,
    input  logic signed [15:0]          out_quat_z,
    input  logic [47:0]                 out_lin_vel,
    input  logic [47:0]                 out_ang_vel,
    input  logic [7:0]                  reset_count,
    output int                          fail_count,
    output int                          pending
);

    typedef struct {
        logic                 ok;
        logic [63:0]          t;
        logic [POS_WIDTH-1:0] n, e, d;
        logic [15:0]          q[4];
        logic [47:0]          lv, av;
        logic [7:0]           rc;
    } ned_sample_t;

    ned_sample_t ned_expected[$];

    // converter state
    logic           seen_time;
    logic [63:0]    prev_time;
    logic           origin_set;
    longint         origin[3];
    logic [7:0]     reversals;

    function automatic logic [15:0] clamp16(input longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic logic [POS_WIDTH-1:0] clamp_pos(input longint v);
        longint hi;
        hi = (longint'(1) <<< (POS_WIDTH - 1)) - 1;
        if (v > hi) v = hi;
        if (v < -hi - 1) v = -hi - 1;
        return v[POS_WIDTH-1:0];
    endfunction

    function automatic logic [47:0] mirror_yz(input logic [47:0] p);
        return {clamp16(-longint'($signed(p[47:32]))),
                clamp16(-longint'($signed(p[31:16]))), p[15:0]};
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned rdiv(input longint unsigned num,
                                             input longint unsigned den);
        return (num + den / 2) / den;
    endfunction

    // off-main component in q2.14 with the sign of its numerator
    function automatic logic [15:0] minor_part(input longint dn, input longint unsigned n2,
                                               input longint unsigned cs);
        longint unsigned mag, t;
        longint v;
        mag = (dn < 0) ? longint'(-dn) : dn;
        t = rdiv(mag << 28, n2);
        v = longint'(rdiv(t << 14, cs));
        return clamp16(dn < 0 ? -v : v);
    endfunction

    // flu/enu quaternion to frd/ned through the permuted rotation matrix
    task automatic rotate_quat(input longint w, input longint x, input longint y,
                               input longint z, output logic [15:0] q[4]);
        longint n2, r00, r01, r02, r10, r11, r12, r20, r21, r22;
        longint m00, m01, m02, m10, m11, m12, m20, m21, m22, tr, a;
        longint dn[3];
        longint unsigned rr, cs;
        int mi, k;
        n2  = w*w + x*x + y*y + z*z;
        r00 = n2 - 2*(y*y + z*z); r01 = 2*(x*y - z*w); r02 = 2*(x*z + y*w);
        r10 = 2*(x*y + z*w); r11 = n2 - 2*(x*x + z*z); r12 = 2*(y*z - x*w);
        r20 = 2*(x*z - y*w); r21 = 2*(y*z + x*w); r22 = n2 - 2*(x*x + y*y);
        m00 = r10;  m01 = -r11; m02 = -r12;
        m10 = r00;  m11 = -r01; m12 = -r02;
        m20 = -r20; m21 = r21;  m22 = r22;
        tr = m00 + m11 + m22;
        if (tr > 0)
        begin
            a = n2 + tr; mi = 0;
            dn[0] = m21 - m12; dn[1] = m02 - m20; dn[2] = m10 - m01;
        end
        else if (m00 > m11 && m00 > m22)
        begin
            a = n2 + m00 - m11 - m22; mi = 1;
            dn[0] = m21 - m12; dn[1] = m01 + m10; dn[2] = m02 + m20;
        end
        else if (m11 > m22)
        begin
            a = n2 + m11 - m00 - m22; mi = 2;
            dn[0] = m02 - m20; dn[1] = m01 + m10; dn[2] = m12 + m21;
        end
        else
        begin
            a = n2 + m22 - m00 - m11; mi = 3;
            dn[0] = m10 - m01; dn[1] = m02 + m20; dn[2] = m12 + m21;
        end
        if (a <= 0) a = 0;
        if (a > (longint'(1) <<< 34)) a = longint'(1) <<< 34;
        rr = (longint'(a) << 28) / longint'(n2);
        if (rr > (64'd1 << 32)) rr = 64'd1 << 32;
        cs = int_sqrt(rr << 30);
        k = 0;
        for (int i = 0; i < 4; i++)
        begin
            if (cs == 0)
                q[i] = '0;
            else if (i == mi)
                q[i] = clamp16(longint'((cs + 64'h8000) >> 16));
            else
            begin
                q[i] = minor_part(dn[k], n2, cs);
                k++;
            end
        end
    endtask

    task automatic predict_ned(output ned_sample_t s);
        longint px, py, pz;
        s.ok = 0; s.t = '0; s.n = '0; s.e = '0; s.d = '0;
        s.lv = '0; s.av = '0; s.rc = '0;
        for (int i = 0; i < 4; i++) s.q[i] = '0;
        if (quat_w == 0 && quat_x == 0 && quat_y == 0 && quat_z == 0)
            return;
        // a backwards step in time drops the origin
        if (seen_time && time_usec < prev_time)
        begin
            reversals  = reversals + 8'd1;
            origin_set = 0;
        end
        prev_time = time_usec;
        seen_time = 1;
        px = pos_x; py = pos_y; pz = pos_z;
        if (!origin_set)
        begin
            origin[0] = px; origin[1] = py; origin[2] = pz;
            origin_set = 1;
        end
        s.ok = 1;
        s.t  = time_usec;
        s.n  = clamp_pos(py - origin[1]);
        s.e  = clamp_pos(px - origin[0]);
        s.d  = clamp_pos(origin[2] - pz);
        rotate_quat(quat_w, quat_x, quat_y, quat_z, s.q);
        s.lv = mirror_yz(lin_vel);
        s.av = mirror_yz(ang_vel);
        s.rc = reversals;
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            if (fail_count < 10)
                $display("field %s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endfunction

    assign pending = ned_expected.size();

    always @(posedge clk or negedge rst_n)
    begin
        ned_sample_t s;
        if (!rst_n)
        begin
            seen_time  <= 0;
            prev_time  <= '0;
            origin_set <= 0;
            origin     <= '{0, 0, 0};
            reversals  <= '0;
            fail_count <= 0;
            ned_expected.delete();
        end
        else
        begin
            // older results leave before the new request is queued
            if (out_valid && out_ready)
            begin
                if (ned_expected.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("result with nothing expected");
                    fail_count++;
                end
                else
                begin
                    // signed result fields are compared as raw bits
                    s = ned_expected.pop_front();
                    check_field("valid_res", s.ok, valid_res);
                    check_field("out_time_usec", s.t, out_time_usec);
                    check_field("north", s.n, $unsigned(north));
                    check_field("east", s.e, $unsigned(east));
                    check_field("down", s.d, $unsigned(down));
                    check_field("out_quat_w", s.q[0], $unsigned(out_quat_w));
                    check_field("out_quat_x", s.q[1], $unsigned(out_quat_x));
                    check_field("out_quat_y", s.q[2], $unsigned(out_quat_y));
                    check_field("out_quat_z", s.q[3], $unsigned(out_quat_z));
                    check_field("out_lin_vel", s.lv, out_lin_vel);
                    check_field("out_ang_vel", s.av, out_ang_vel);
                    check_field("reset_count", s.rc, reset_count);
                end
            end
            if (in_valid && in_ready)
            begin
                predict_ned(s);
                ned_expected.push_back(s);
            end
        end
    end

endmodule

/* bench/enu_to_ned_odometry_converter_tb.sv */
// testbench top for the enu to ned odometry converter: stimulus and verdict
module enu_to_ned_odometry_converter_tb;

    localparam int POS_WIDTH   = 32;
    localparam int CYCLE_LIMIT = 2000000;

    logic                        clk = 0;
    logic                        rst_n = 0;
    logic                        in_valid = 0;
    logic                        in_ready;
    logic [63:0]                 time_usec = '0;
    logic signed [POS_WIDTH-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [15:0]          quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
    logic [47:0]                 lin_vel = '0, ang_vel = '0;
    logic                        out_valid;
    logic                        out_ready = 0;
    logic                        valid_res;
    logic [63:0]                 out_time_usec;
    logic signed [POS_WIDTH-1:0] north, east, down;
    logic signed [15:0]          out_quat_w, out_quat_x, out_quat_y, out_quat_z;
    logic [47:0]                 out_lin_vel, out_ang_vel;
    logic [7:0]                  reset_count;
    int                          fail_count;
    int                          pending;
    int                          cycles = 0;
    int                          stall_mode = 0;
    logic [63:0]                 clock_now = 64'd1000;

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    enu_to_ned_odometry_converter #(.POS_WIDTH(POS_WIDTH)) uut (.*);

    enu_to_ned_odometry_checker #(.POS_WIDTH(POS_WIDTH)) chk (.*);

    // receiver stalls: always ready, random, or long pauses
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 2) != 0);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("enu_to_ned_odometry_converter: mismatch");
            $finish;
        end
    end

    // present one odometry request and hold it until accepted
    task automatic send_odom(input logic [63:0] t, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] pz,
                             input logic [15:0] qw, input logic [15:0] qx,
                             input logic [15:0] qy, input logic [15:0] qz,
                             input logic [47:0] lv, input logic [47:0] av);
        in_valid  <= 1'b1;
        time_usec <= t;
        pos_x <= px; pos_y <= py; pos_z <= pz;
        quat_w <= qw; quat_x <= qx; quat_y <= qy; quat_z <= qz;
        lin_vel <= lv; ang_vel <= av;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 9)
                                                 : 32'h80000000 + $urandom_range(0, 9);
            default: return 32'($signed($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    function automatic logic [15:0] rand_quat();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom);
            1:       return 16'($signed($urandom_range(0, 32768)) - 16384);
            2:       return 16'($signed($urandom_range(0, 20)) - 10);
            3:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            default: return 16'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    function automatic logic [47:0] rand_vel();
        logic [47:0] v;
        v = 48'({$urandom, $urandom});
        for (int i = 0; i < 3; i++)
            if ($urandom_range(0, 5) == 0)
                v[16*i +: 16] = 16'h8000;
        return v;
    endfunction

    initial
    begin
        logic [15:0] qw, qx, qy, qz;
        int          burst;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero quaternion before anything else
        send_odom(64'd500, 32'h1234, 32'h5678, 32'h9abc, 0, 0, 0, 0,
                  48'hffffffffffff, 48'h800080008000);
        // first valid sample sets the origin
        send_odom(64'd1000, 32'h00010000, 32'h00020000, 32'h00030000,
                  16'h4000, 0, 0, 0, 48'h800080008000, 48'h7fff7fff7fff);
        // each axis of the quaternion, and the extremes
        send_odom(64'd1000, 32'h7fffffff, 32'h80000000, 32'h80000000,
                  0, 16'h4000, 0, 0, 48'h0, 48'hffffffffffff);
        send_odom(64'd1001, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                  0, 0, 16'h4000, 0, 48'h123456789abc, 48'h0);
        send_odom(64'd1002, 0, 0, 0, 0, 0, 0, 16'h4000, 48'h1, 48'h10000);
        send_odom(64'd1003, 1, 2, 3, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                  48'h800000000000, 48'h000080000000);
        send_odom(64'd1004, 4, 5, 6, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                  48'hffff0000ffff, 48'h0000ffff0000);
        send_odom(64'd1005, 7, 8, 9, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                  48'h7fff80007fff, 48'h80007fff8000);
        send_odom(64'd1006, 9, 8, 7, 16'h0001, 0, 0, 0, 48'h0, 48'h0);
        send_odom(64'd1007, 9, 8, 7, 0, 0, 0, 16'hffff, 48'h0, 48'h0);
        send_odom(64'd1008, 9, 8, 7, 16'h2d41, 16'h2d41, 0, 0, 48'h0, 48'h0);
        send_odom(64'd1009, 9, 8, 7, 16'h2000, 16'he000, 16'h2000, 16'he000,
                  48'h0, 48'h0);
        // time reversal drops the origin, the zero quaternion does not count
        send_odom(64'd100, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0,
                  48'h0, 48'h0);
        send_odom(64'd900, 32'h40000000, 32'hc0000000, 32'h00000001,
                  16'h4000, 0, 0, 0, 48'h0, 48'h0);
        send_odom(64'd900, 32'h80000000, 32'h7fffffff, 32'h80000000,
                  16'h4000, 0, 0, 0, 48'h0, 48'h0);
        send_odom(64'hffffffffffffffff, 0, 0, 0, 16'h4000, 0, 0, 0, 48'h0, 48'h0);
        send_odom(64'd0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  16'h4000, 0, 0, 0, 48'h0, 48'h0);
        send_odom(64'd0, 32'h80000000, 32'h80000000, 32'h80000000,
                  16'h4000, 0, 0, 0, 48'h0, 48'h0);
        in_valid <= 1'b0;

        // hold off until every result of the directed part has come back
        wait (pending == 0);
        @(posedge clk);

        for (int n = 0; n < 450; n += burst)
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++)
            begin
                qw = rand_quat(); qx = rand_quat(); qy = rand_quat(); qz = rand_quat();
                if ($urandom_range(0, 15) == 0)
                begin
                    qw = 0; qx = 0; qy = 0; qz = 0;
                end
                // mostly forward time, sometimes a step back or a random jump
                case ($urandom_range(0, 19))
                    0:       clock_now = clock_now - $urandom_range(1, 5000);
                    1:       clock_now = {$urandom, $urandom};
                    2:       clock_now = clock_now;
                    default: clock_now = clock_now + $urandom_range(1, 20000);
                endcase
                send_odom(clock_now, rand_pos(), rand_pos(), rand_pos(),
                          qw, qx, qy, qz, rand_vel(), rand_vel());
            end
            in_valid <= 1'b0;
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 400)) @(posedge clk);
        end
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("enu_to_ned_odometry_converter: match");
        else
            $display("enu_to_ned_odometry_converter: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
rtl/e2n_pkg.sv
rtl/e2n_iter_unit.sv
rtl/enu_to_ned_odometry_converter.sv
bench/enu_to_ned_odometry_checker.sv
bench/enu_to_ned_odometry_converter_tb.sv
